### rtl/core/u8u16_pkg.sv
package u8u16_pkg;

  localparam int unsigned UNITS_MAX = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] REPLACE_UNIT = 16'h003F;
  localparam logic [15:0] HIGH_BASE = 16'hD800;
  localparam logic [5:0] LOW_TAG = 6'b110111;
  localparam logic [20:0] PLANE_BASE = 21'h010000;

  // sequence lengths of held lead bytes
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // all units caused by one input byte
  typedef struct packed {
    logic [UNITS_MAX-1:0][15:0] units;
    logic [2:0] count;
    logic fin;
  } entry_t;

endpackage

### rtl/core/u8u16_front.sv
module u8u16_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_byte,
  input  logic in_final,
  input  logic push_ready,
  output logic push,
  output u8u16_pkg::entry_t push_entry
);

  logic [20:0] partial_point;
  logic [1:0] held_count;
  logic [2:0] sequence_length;
  logic [20:0] partial_point_next;
  logic [1:0] held_count_next;
  logic [2:0] sequence_length_next;

  logic [3:0][15:0] units;
  logic [2:0] n;
  logic do_fresh;
  logic [20:0] delta;
  logic accept;

  assign in_ready = push_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    partial_point_next = partial_point;
    held_count_next = held_count;
    sequence_length_next = sequence_length;
    units = '0;
    n = 3'd0;
    do_fresh = 1'b0;
    delta = '0;

    if (held_count != 2'd0) begin
      if (in_byte[7:6] == 2'b10) begin
        partial_point_next = {partial_point[14:0], in_byte[5:0]};
        held_count_next = held_count + 2'd1;
        if (held_count_next == 2'd0 || {1'b0, held_count_next} >= sequence_length) begin
          // complete code point: one unit or a surrogate pair
          if (partial_point_next[20:16] == 5'd0) begin
            units[0] = partial_point_next[15:0];
            n = 3'd1;
          end else begin
            delta = partial_point_next - u8u16_pkg::PLANE_BASE;
            units[0] = u8u16_pkg::HIGH_BASE + {5'd0, delta[20:10]};
            units[1] = {u8u16_pkg::LOW_TAG, delta[9:0]};
            n = 3'd2;
          end
          partial_point_next = '0;
          held_count_next = 2'd0;
          sequence_length_next = u8u16_pkg::SEQ_NONE;
        end
      end else begin
        // broken sequence: one replacement per held byte
        for (int k = 0; k < 3; k++) begin
          if (k < int'(held_count)) begin
            units[n[1:0]] = u8u16_pkg::REPLACE_UNIT;
            n = n + 3'd1;
          end
        end
        partial_point_next = '0;
        held_count_next = 2'd0;
        sequence_length_next = u8u16_pkg::SEQ_NONE;
        do_fresh = 1'b1;
      end
    end else begin
      do_fresh = 1'b1;
    end

    if (do_fresh) begin
      case (in_byte) inside
        [8'h00:8'h7F]: begin
          units[n[1:0]] = {8'h00, in_byte};
          n = n + 3'd1;
        end
        [8'hC0:8'hDF]: begin
          partial_point_next = {16'd0, in_byte[4:0]};
          held_count_next = 2'd1;
          sequence_length_next = u8u16_pkg::SEQ_TWO;
        end
        [8'hE0:8'hEF]: begin
          partial_point_next = {17'd0, in_byte[3:0]};
          held_count_next = 2'd1;
          sequence_length_next = u8u16_pkg::SEQ_THREE;
        end
        [8'hF0:8'hF7]: begin
          partial_point_next = {18'd0, in_byte[2:0]};
          held_count_next = 2'd1;
          sequence_length_next = u8u16_pkg::SEQ_FOUR;
        end
        default: begin
          // stray continuation or invalid lead
          units[n[1:0]] = u8u16_pkg::REPLACE_UNIT;
          n = n + 3'd1;
        end
      endcase
    end

    // truncated sequence at end of string
    if (in_final && held_count_next != 2'd0) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(held_count_next) && n < 3'd4) begin
          units[n[1:0]] = u8u16_pkg::REPLACE_UNIT;
          n = n + 3'd1;
        end
      end
      partial_point_next = '0;
      held_count_next = 2'd0;
      sequence_length_next = u8u16_pkg::SEQ_NONE;
    end
  end

  assign push = accept && (n != 3'd0);
  assign push_entry.units = units;
  assign push_entry.count = n;
  assign push_entry.fin = in_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point <= '0;
      held_count <= 2'd0;
      sequence_length <= u8u16_pkg::SEQ_NONE;
    end else if (accept) begin
      partial_point <= partial_point_next;
      held_count <= held_count_next;
      sequence_length <= sequence_length_next;
    end
  end

endmodule

### rtl/core/u8u16_fifo.sv
module u8u16_fifo (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  u8u16_pkg::entry_t push_entry,
  input  logic pop,
  output logic head_valid,
  output u8u16_pkg::entry_t head_entry
);

  localparam int unsigned PW = $clog2(u8u16_pkg::QUEUE_DEPTH);

  u8u16_pkg::entry_t mem [u8u16_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0] fill;

  assign push_ready = (fill != (PW+1)'(u8u16_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW+1)'(1);
      end
    end
  end

endmodule

### rtl/core/u8u16_back.sv
module u8u16_back (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  u8u16_pkg::entry_t push_entry,
  output logic out_valid,
  input  logic out_ready,
  output logic [15:0] code_unit,
  output logic run_last,
  output logic string_end
);

  logic pop;
  logic head_valid;
  u8u16_pkg::entry_t head_entry;

  // per-byte unit bundles wait here
  u8u16_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // one unit per output beat
  u8u16_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_unit  (code_unit),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

### rtl/core/u8u16_emit.sv
module u8u16_emit (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  u8u16_pkg::entry_t head_entry,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output logic [15:0] code_unit,
  output logic run_last,
  output logic string_end
);

  logic [1:0] idx;
  logic load;
  logic take;
  logic is_last;

  // output register is free when empty or being drained this cycle
  assign load = !out_valid || out_ready;
  assign take = load && head_valid;
  assign is_last = ({1'b0, idx} == (head_entry.count - 3'd1));
  assign pop = take && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= 2'd0;
    end else if (load) begin
      out_valid <= head_valid;
      if (take) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code_unit <= head_entry.units[idx];
      run_last <= is_last;
      string_end <= is_last && head_entry.fin;
    end
  end

endmodule

### rtl/core/utf8_to_utf16_transcoder_unit.sv
// utf8 to utf16 transcoder
// input channel: one utf-8 byte per beat (in_byte) with in_final set on the
//   last byte of a string; in_valid / in_ready handshake
// output channel: one utf-16 code unit per beat (code_unit), with run_last on
//   the last unit caused by a byte and string_end on the last unit of a string
// a byte may cause zero to four units: lead bytes and unfinished sequences
//   give none, completed points one or a surrogate pair, malformed input one
//   '?' per held byte plus whatever the current byte gives
// the first unit of a byte passes through the queue and then the output
//   register before its own beat, and a stall can hold it in either
// throughput: one byte per cycle in; one unit per cycle out while out_ready
//   is high; the front takes a byte while the four-entry unit queue has room
// a byte with several units holds the queue head for that many output beats
// when the receiver stalls, the output register holds, the queue fills, and
//   then in_ready drops until an entry drains (it stays low in a full cycle
//   even if the head leaves at that edge)
// reset: clears the held sequence, empties the queue and drops out_valid
module utf8_to_utf16_transcoder_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_byte,
  input  logic in_final,
  output logic out_valid,
  input  logic out_ready,
  output logic [15:0] code_unit,
  output logic run_last,
  output logic string_end
);

  // front to back, through the queue
  logic push;
  logic push_ready;
  u8u16_pkg::entry_t push_entry;

  // decode and classify each byte, keep the partial code point
  u8u16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_final   (in_final),
    .push_ready (push_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  // short queue of per-byte unit bundles, then serialize each bundle,
  // one unit per output beat
  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_unit  (code_unit),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule
